### rtl/core/fctl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctl_pkg: shared types and constants of the call trace lookup
// Item, result and command formats, operation codes, register indexes and
// the depth constants that the front part relies on.
// ----------------------------------------------------------------------------
package fctl_pkg;

    // Default size of the symbol table.
    localparam int unsigned SYMBOLS_DEFAULT = 64;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT  = 1'd1;

    // Call depth handling.
    localparam logic [15:0] DEPTH_MAX   = 16'hFFFF;
    localparam logic [15:0] QUIET_DEPTH = 16'd2;
    localparam logic [15:0] INDENT_BASE = 16'd3;

    // Input item action codes.
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_CALL   = 2'd1,
        ACT_RETURN = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_CALL,
        CMD_RETURN
    } t_cmd_kind;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  entry_index;
        logic [31:0] entry_start;
        logic [31:0] entry_length;
        logic        entry_is_func;
        logic [31:0] event_pc;
        logic [31:0] target_addr;
    } t_in_item;

    typedef struct packed {
        logic        is_return;
        logic [15:0] indent_level;
        logic        found;
        logic [5:0]  symbol_index;
        logic [31:0] pc_out;
        logic [31:0] target_out;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [5:0]  slot;
        logic [31:0] start;
        logic [31:0] length;
        logic        is_func;
        logic [31:0] pc;
        logic [31:0] target;
        logic [15:0] indent;
    } t_cmd;

endpackage

### rtl/core/function_call_trace_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// function_call_trace_lookup: call and return symbol lookup for tracing
// Keeps a symbol table and a call depth and reports, for each traced call or
// return, the matching function entry and the indent level.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle as long as its two-entry command
// queue has room. Load beats write one symbol table slot as the back takes
// them. A call or return that reports passes the back part in order: the
// back takes the command, reads up to the smaller of table_count and SYMBOLS
// entries in turn, tests each word on the registered read and holds the
// result on the output register while the output stalls. The scan is set by
// the single read port of the symbol table memory, which is read one entry
// per cycle, and it stops at the first match. Calls and returns that do not
// report (tracing disabled, or a depth of two or less) and unused action
// codes are absorbed by the front and never reach the back. Configuration
// is written through a plain write port: index 0 is trace_enable and index
// 1 is table_count; it is meant to be written while the block is idle.
// ----------------------------------------------------------------------------
module function_call_trace_lookup #(
    parameter int unsigned SYMBOLS = fctl_pkg::SYMBOLS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [fctl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fctl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input beats.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fctl_pkg::t_in_item                  i_in_data,
    // Result beats.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fctl_pkg::t_out_item                 o_out_data
);

    // Configuration registers.
    logic                            r_trace_enable;
    logic [fctl_pkg::CFG_DATA_W-1:0] r_table_count;

    // Front to queue and queue to back.
    logic           push;
    fctl_pkg::t_cmd push_cmd;
    logic           q_full;
    logic           q_valid;
    fctl_pkg::t_cmd q_cmd;
    logic           q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_enable <= 1'b0;
            r_table_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fctl_pkg::CFG_TRACE_ENABLE: r_trace_enable <= i_cfg_data[0];
                fctl_pkg::CFG_TABLE_COUNT:  r_table_count  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front classifies each beat and tracks the call depth, so the
    // depth seen by a command is fixed in input order.
    fctl_front #(
        .SYMBOLS (SYMBOLS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_item         (i_in_data),
        .i_trace_enable (r_trace_enable),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    fctl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // The back applies table writes and lookups strictly in queue order,
    // so a lookup always sees every load that came before it.
    fctl_back #(
        .SYMBOLS (SYMBOLS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .i_table_count (r_table_count),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_item        (o_out_data)
    );

endmodule

### rtl/core/fctl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctl_front: input classification and call depth tracking
// Accepts input beats, keeps the saturating call depth and turns each beat
// into a table write, a lookup command or nothing.
// ----------------------------------------------------------------------------
module fctl_front #(
    parameter int unsigned SYMBOLS = fctl_pkg::SYMBOLS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  fctl_pkg::t_in_item i_item,
    input  logic               i_trace_enable,
    input  logic               i_q_full,
    output logic               o_push,
    output fctl_pkg::t_cmd     o_cmd
);

    logic [15:0] r_depth;
    logic [15:0] n_depth;
    logic [15:0] depth_up;
    logic        accept;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;

    always_comb begin
        n_depth  = r_depth;
        o_push   = 1'b0;
        depth_up = (r_depth < fctl_pkg::DEPTH_MAX) ? r_depth + 16'd1 : r_depth;

        o_cmd.kind    = fctl_pkg::CMD_LOAD;
        o_cmd.slot    = i_item.entry_index;
        o_cmd.start   = i_item.entry_start;
        o_cmd.length  = i_item.entry_length;
        o_cmd.is_func = i_item.entry_is_func;
        o_cmd.pc      = i_item.event_pc;
        o_cmd.target  = i_item.target_addr;
        o_cmd.indent  = r_depth - fctl_pkg::INDENT_BASE;

        case (i_item.action)
            fctl_pkg::ACT_LOAD: begin
                // Slots beyond the table are dropped here.
                if (32'(i_item.entry_index) < SYMBOLS) begin
                    o_push = accept;
                end
            end
            fctl_pkg::ACT_CALL: begin
                o_cmd.kind   = fctl_pkg::CMD_CALL;
                o_cmd.indent = depth_up - fctl_pkg::INDENT_BASE;
                if (i_trace_enable) begin
                    if (accept) begin
                        n_depth = depth_up;
                    end
                    if (depth_up > fctl_pkg::QUIET_DEPTH) begin
                        o_push = accept;
                    end
                end
            end
            fctl_pkg::ACT_RETURN: begin
                o_cmd.kind   = fctl_pkg::CMD_RETURN;
                o_cmd.target = 32'd0;
                if (i_trace_enable && r_depth > fctl_pkg::QUIET_DEPTH) begin
                    o_push = accept;
                    if (accept) begin
                        n_depth = r_depth - 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= 16'd0;
        end else begin
            r_depth <= n_depth;
        end
    end

endmodule

### rtl/core/fctl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctl_queue: two-entry command queue
// Decouples the front from the back so that each side can stall on its own.
// ----------------------------------------------------------------------------
module fctl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fctl_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fctl_pkg::t_cmd o_cmd
);

    fctl_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/fctl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fctl_back: symbol table and lookup sequencer
// Holds the symbol table memory, applies table writes and scans the table
// one entry per cycle for calls and returns, then presents the result beat.
// ----------------------------------------------------------------------------
module fctl_back #(
    parameter int unsigned SYMBOLS = fctl_pkg::SYMBOLS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  fctl_pkg::t_cmd                      i_q_cmd,
    output logic                                o_q_pop,
    input  logic [fctl_pkg::CFG_DATA_W-1:0]     i_table_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output fctl_pkg::t_out_item                 o_item
);

    localparam int unsigned IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int unsigned CNT_W = $clog2(SYMBOLS + 1);

    // Symbol table memory, one write and one registered read per cycle.
    logic [31:0] mem_start  [SYMBOLS];
    logic [31:0] mem_length [SYMBOLS];
    logic        mem_func   [SYMBOLS];
    logic [31:0] r_rd_start;
    logic [31:0] r_rd_length;
    logic        r_rd_func;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_addr_ext;
    logic             wr_en;

    fctl_pkg::t_back_state r_state;
    fctl_pkg::t_back_state n_state;
    fctl_pkg::t_cmd        r_cmd;
    fctl_pkg::t_cmd        n_cmd;
    logic [CNT_W-1:0]      r_limit;
    logic [CNT_W-1:0]      n_limit;
    logic [CNT_W-1:0]      r_iss_idx;
    logic [CNT_W-1:0]      n_iss_idx;
    logic [CNT_W-1:0]      iss_next;
    logic                  r_iss_on;
    logic                  n_iss_on;
    logic                  r_chk_on;
    logic                  n_chk_on;
    logic [IDX_W-1:0]      r_chk_idx;
    logic [IDX_W-1:0]      n_chk_idx;
    fctl_pkg::t_out_item   r_out;
    fctl_pkg::t_out_item   n_out;
    logic [31:0]           lim_ext;
    logic [31:0]           chk_idx_ext;
    logic [31:0]           look_addr;
    logic [32:0]           range_end;
    logic                  hit;

    assign wr_addr_ext = 32'(i_q_cmd.slot);
    assign wr_addr     = wr_addr_ext[IDX_W-1:0];
    assign rd_addr     = r_iss_idx[IDX_W-1:0];
    assign iss_next    = r_iss_idx + CNT_W'(1);
    assign lim_ext     = (32'(i_table_count) > SYMBOLS) ? SYMBOLS : 32'(i_table_count);
    assign chk_idx_ext = 32'(r_chk_idx);

    // Entry test on the word read out in the previous cycle.
    assign look_addr = (r_cmd.kind == fctl_pkg::CMD_CALL) ? r_cmd.target : r_cmd.pc;
    assign range_end = {1'b0, r_rd_start} + {1'b0, r_rd_length};
    always_comb begin
        if (r_cmd.kind == fctl_pkg::CMD_CALL) begin
            hit = r_rd_func && (r_rd_start == look_addr);
        end else begin
            hit = r_rd_func && (r_rd_start <= look_addr) && ({1'b0, look_addr} < range_end);
        end
    end

    assign o_valid = (r_state == fctl_pkg::BK_OUT);
    assign o_item  = r_out;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_limit   = r_limit;
        n_iss_idx = r_iss_idx;
        n_iss_on  = 1'b0;
        n_chk_on  = 1'b0;
        n_chk_idx = r_chk_idx;
        n_out     = r_out;
        o_q_pop   = 1'b0;
        wr_en     = 1'b0;

        case (r_state)
            fctl_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    if (i_q_cmd.kind == fctl_pkg::CMD_LOAD) begin
                        wr_en = 1'b1;
                    end else begin
                        n_limit            = lim_ext[CNT_W-1:0];
                        n_iss_idx          = '0;
                        n_out.is_return    = (i_q_cmd.kind == fctl_pkg::CMD_RETURN);
                        n_out.indent_level = i_q_cmd.indent;
                        n_out.found        = 1'b0;
                        n_out.symbol_index = 6'd0;
                        n_out.pc_out       = i_q_cmd.pc;
                        n_out.target_out   = i_q_cmd.target;
                        if (lim_ext == 32'd0) begin
                            n_state = fctl_pkg::BK_OUT;
                        end else begin
                            n_iss_on = 1'b1;
                            n_state  = fctl_pkg::BK_SCAN;
                        end
                    end
                end
            end
            fctl_pkg::BK_SCAN: begin
                if (r_iss_on) begin
                    n_chk_on  = 1'b1;
                    n_chk_idx = rd_addr;
                    n_iss_idx = iss_next;
                    n_iss_on  = (iss_next != r_limit);
                end
                if (r_chk_on && hit) begin
                    n_out.found        = 1'b1;
                    n_out.symbol_index = chk_idx_ext[5:0];
                    n_iss_on           = 1'b0;
                    n_chk_on           = 1'b0;
                    n_state            = fctl_pkg::BK_OUT;
                end else if (r_chk_on && !r_iss_on) begin
                    n_state = fctl_pkg::BK_OUT;
                end
            end
            fctl_pkg::BK_OUT: begin
                if (!i_stall) begin
                    n_state = fctl_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = fctl_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fctl_pkg::BK_IDLE;
            r_iss_on <= 1'b0;
            r_chk_on <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_iss_on <= n_iss_on;
            r_chk_on <= n_chk_on;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_limit   <= n_limit;
        r_iss_idx <= n_iss_idx;
        r_chk_idx <= n_chk_idx;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_start[wr_addr]  <= i_q_cmd.start;
            mem_length[wr_addr] <= i_q_cmd.length;
            mem_func[wr_addr]   <= i_q_cmd.is_func;
        end
        r_rd_start  <= mem_start[rd_addr];
        r_rd_length <= mem_length[rd_addr];
        r_rd_func   <= mem_func[rd_addr];
    end

endmodule
